// ----- rtl/spq_pkg.sv -----
// ----------------------------------------------------------------------------
// spq_pkg - shared types and constants for the stable priority queue
// Entry layout, controller/datapath command and status groups, codes.
// ----------------------------------------------------------------------------
package spq_pkg;

   localparam int QUEUE_DEPTH   = 64;
   localparam int COUNT_W       = $clog2(QUEUE_DEPTH + 1);
   localparam int ENTRY_COUNT_W = 7;
   localparam int ID_W          = 16;
   localparam int MARK_W        = 16;
   localparam int ARRIVAL_W     = 32;
   localparam int STATUS_W      = 2;

   localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

   localparam logic CMD_ENQUEUE = 1'b0;
   localparam logic CMD_DEQUEUE = 1'b1;

   typedef struct packed {
      logic [ID_W-1:0]      id;
      logic [MARK_W-1:0]    mark;
      logic [ARRIVAL_W-1:0] arrival;
   } entry_type;

   typedef enum logic [1:0] {
      OP_NONE,
      OP_INSERT,
      OP_REMOVE
   } op_type;

   typedef enum logic {
      S_IDLE,
      S_UPDATE
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic                capture;
      op_type              op;
      logic                bump_arrival;
      logic                load_rsp;
      logic [STATUS_W-1:0] status;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic is_dequeue;
      logic is_full;
      logic is_empty;
   } stat_type;

endpackage

// ----- rtl/stable_priority_queue.sv -----
// ----------------------------------------------------------------------------
// stable_priority_queue - bounded job queue kept sorted by mark, then arrival
// Enqueue stamps an arrival number and inserts; dequeue returns the head.
//
//   channel  direction  handshake           payload
//   req      in         req_valid/req_stall command, job_id, marks
//   rsp      out        rsp_valid/rsp_stall status, out_job_id, out_marks,
//                                           out_arrival, entry_count
//
// Accepting a request registers the mark compare against every held entry;
// once the response slot is free or draining, the sorted array shifts and
// the response is loaded. Further requests wait while a response is stalled
// and one more request has already been taken. Reset is synchronous and
// empties the queue and zeroes the arrival counter; no clearing pass.
// ----------------------------------------------------------------------------
module stable_priority_queue (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_command,
   input  logic [spq_pkg::ID_W-1:0]          req_job_id,
   input  logic [spq_pkg::MARK_W-1:0]        req_marks,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [spq_pkg::STATUS_W-1:0]      rsp_status,
   output logic [spq_pkg::ID_W-1:0]          rsp_out_job_id,
   output logic [spq_pkg::MARK_W-1:0]        rsp_out_marks,
   output logic [spq_pkg::ARRIVAL_W-1:0]     rsp_out_arrival,
   output logic [spq_pkg::ENTRY_COUNT_W-1:0] rsp_entry_count
);
   import spq_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   spq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   spq_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_command     (req_command),
      .req_job_id      (req_job_id),
      .req_marks       (req_marks),
      .rsp_status      (rsp_status),
      .rsp_out_job_id  (rsp_out_job_id),
      .rsp_out_marks   (rsp_out_marks),
      .rsp_out_arrival (rsp_out_arrival),
      .rsp_entry_count (rsp_entry_count)
   );

endmodule

// ----- rtl/spq_ctrl.sv -----
// ----------------------------------------------------------------------------
// spq_ctrl - request sequencer for the stable priority queue
// Takes a request, picks the queue operation and status, loads the response.
// ----------------------------------------------------------------------------
module spq_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   input  spq_pkg::stat_type stat,
   output spq_pkg::cmd_type  cmd
);
   import spq_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      go;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   // response slot is free or drains this cycle
   assign go = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in         = state_ff;
      cmd              = '0;
      cmd.op           = OP_NONE;
      cmd.status       = ST_DONE;
      rsp_valid_in     = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         S_IDLE: begin
            cmd.capture = req_valid;
            if (req_valid) state_in = S_UPDATE;
         end
         S_UPDATE: begin
            if (go) begin
               cmd.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
               if (!stat.is_dequeue) begin
                  cmd.bump_arrival = 1'b1;
                  if (stat.is_full) cmd.status = ST_FULL;
                  else              cmd.op     = OP_INSERT;
               end else begin
                  if (stat.is_empty) cmd.status = ST_EMPTY;
                  else               cmd.op     = OP_REMOVE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule

// ----- rtl/spq_datapath.sv -----
// ----------------------------------------------------------------------------
// spq_datapath - sorted entry array, counters and response register
// Compares all held marks at capture, then inserts or pops with one shift.
// ----------------------------------------------------------------------------
module spq_datapath (
   input  logic                           clock,
   input  logic                           reset,
   input  spq_pkg::cmd_type               cmd,
   output spq_pkg::stat_type              stat,
   input  logic                           req_command,
   input  logic [spq_pkg::ID_W-1:0]       req_job_id,
   input  logic [spq_pkg::MARK_W-1:0]     req_marks,
   output logic [spq_pkg::STATUS_W-1:0]   rsp_status,
   output logic [spq_pkg::ID_W-1:0]       rsp_out_job_id,
   output logic [spq_pkg::MARK_W-1:0]     rsp_out_marks,
   output logic [spq_pkg::ARRIVAL_W-1:0]  rsp_out_arrival,
   output logic [spq_pkg::ENTRY_COUNT_W-1:0] rsp_entry_count
);
   import spq_pkg::*;

   entry_type             slot_ff [QUEUE_DEPTH];
   entry_type             slot_in [QUEUE_DEPTH];
   logic [QUEUE_DEPTH-1:0] ge_ff, ge_in;
   logic                  command_ff;
   logic [ID_W-1:0]       id_ff;
   logic [MARK_W-1:0]     mark_ff;
   logic [COUNT_W-1:0]    count_ff, count_in;
   logic [ARRIVAL_W-1:0]  arrival_ff;
   entry_type             new_entry;

   logic [STATUS_W-1:0]   status_ff;
   entry_type             head_ff;
   logic [COUNT_W-1:0]    rsp_count_ff;

   // ge[i]: held entry i stays ahead of the new job (prefix of ones)
   always_comb begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         ge_in[i] = (COUNT_W'(i) < count_ff) && (slot_ff[i].mark >= req_marks);
      end
   end

   assign new_entry = '{id: id_ff, mark: mark_ff, arrival: arrival_ff};

   always_comb begin
      count_in = count_ff;
      for (int i = 0; i < QUEUE_DEPTH; i++) slot_in[i] = slot_ff[i];
      case (cmd.op)
         OP_INSERT: begin
            count_in = count_ff + 1'b1;
            if (!ge_ff[0]) slot_in[0] = new_entry;
            for (int i = 1; i < QUEUE_DEPTH; i++) begin
               if (!ge_ff[i]) slot_in[i] = ge_ff[i-1] ? new_entry : slot_ff[i-1];
            end
         end
         OP_REMOVE: begin
            count_in = count_ff - 1'b1;
            for (int i = 0; i < QUEUE_DEPTH - 1; i++) slot_in[i] = slot_ff[i+1];
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         arrival_ff <= '0;
      end else begin
         count_ff <= count_in;
         if (cmd.bump_arrival) arrival_ff <= arrival_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < QUEUE_DEPTH; i++) slot_ff[i] <= slot_in[i];
      if (cmd.capture) begin
         command_ff <= req_command;
         id_ff      <= req_job_id;
         mark_ff    <= req_marks;
         ge_ff      <= ge_in;
      end
      if (cmd.load_rsp) begin
         status_ff    <= cmd.status;
         head_ff      <= (cmd.op == OP_REMOVE) ? slot_ff[0] : '0;
         rsp_count_ff <= count_in;
      end
   end

   assign stat.is_dequeue = (command_ff == CMD_DEQUEUE);
   assign stat.is_full    = (count_ff == COUNT_W'(QUEUE_DEPTH));
   assign stat.is_empty   = (count_ff == '0);

   assign rsp_status      = status_ff;
   assign rsp_out_job_id  = head_ff.id;
   assign rsp_out_marks   = head_ff.mark;
   assign rsp_out_arrival = head_ff.arrival;
   assign rsp_entry_count = ENTRY_COUNT_W'(rsp_count_ff);

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(QUEUE_DEPTH))
      else $error("entry count above depth");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      cmd.op == OP_INSERT |=> count_ff == COUNT_W'($past(count_ff) + 1'b1))
      else $error("insert did not add one entry");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      cmd.op == OP_REMOVE |-> count_ff != '0)
      else $error("pop from empty queue");

   a_no_insert_full: assert property (@(posedge clock) disable iff (reset)
      cmd.op == OP_INSERT |-> !stat.is_full && !stat.is_dequeue)
      else $error("insert while full or on dequeue");

endmodule
